>>> hw/rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; every other file of the block imports this package.
package lr_pkg;

  // Item kind carried on kind_i and through the command queue.
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // Depth of the command queue between front and back.
  localparam int unsigned CmdDepth = 2;

endpackage

>>> hw/rtl/line_rasterizer.sv
// Top level of the line rasterizer: front, command queue and back.
// Depends on lr_pkg, lr_front, lr_cmd_fifo and lr_back.
//
// All-octant Bresenham line generator. Push a load beat (kind 0) with both
// endpoints to start a line; it yields the start pixel. Each tick beat
// (kind 1) yields the next pixel; the pixel on the end point has last set,
// after which ticks are dropped without a result until the next load. A load
// during a running line abandons it. Items are accepted at one per clock
// while full is low, and the back produces one pixel per clock while its
// result is popped: each step is one add-and-compare pass of the error term
// in the back's stepper. An accepted beat lands in the two-entry command
// queue, and the stepper takes it from there straight into its result
// register once that register is empty or being popped. The command queue
// lets the front keep taking beats while a pixel waits to be popped; full
// rises only once two beats are queued behind an unpopped result.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  lr_pkg::kind_e         kind_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_o
);
  import lr_pkg::*;

  // Kind, four coordinates, two spans, two direction bits, error term.
  localparam int unsigned CmdW = 7 * COORD_BITS + 5;

  logic            cmd_push;
  logic [CmdW-1:0] cmd_wdata;
  logic            cmd_full;
  logic            cmd_valid;
  logic            cmd_pop;
  logic [CmdW-1:0] cmd_rdata;

  // Classify and set up each beat.
  lr_front #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CmdW)
  ) u_front (
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wdata)
  );

  // Hold commands until the stepper takes them.
  lr_cmd_fifo #(
    .WIDTH (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_rdata)
  );

  // Step the line and present pixels.
  lr_back #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CmdW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_rdata),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_o      (last_o)
  );

endmodule

>>> hw/rtl/lr_front.sv
// Front of the line rasterizer: accepts beats, classifies them and
// precomputes the per-line setup (spans, step directions, initial error).
// Depends on lr_pkg.
module lr_front #(
  parameter int unsigned COORD_BITS = 8,
  parameter int unsigned CMD_W      = 7 * COORD_BITS + 5
) (
  input  logic                  push,
  output logic                  full,
  input  lr_pkg::kind_e         kind_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  cmd_full_i,
  output logic                  cmd_push_o,
  output logic [CMD_W-1:0]      cmd_o
);
  import lr_pkg::*;

  logic [COORD_BITS-1:0] span_x;
  logic [COORD_BITS-1:0] span_y;
  logic                  dir_x_neg;
  logic                  dir_y_neg;
  logic [COORD_BITS+1:0] err_init;

  // Absolute spans and step directions; equal coordinates count as negative.
  assign span_x    = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign span_y    = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
  assign dir_x_neg = !(start_x_i < end_x_i);
  assign dir_y_neg = !(start_y_i < end_y_i);
  assign err_init  = {2'b00, span_x} - {2'b00, span_y};

  assign full       = cmd_full_i;
  assign cmd_push_o = push && !cmd_full_i;
  assign cmd_o      = {kind_i, start_x_i, start_y_i, end_x_i, end_y_i,
                       span_x, span_y, dir_x_neg, dir_y_neg, err_init};

endmodule

>>> hw/rtl/lr_cmd_fifo.sv
// Short command queue that decouples the front from the back.
// Depends on lr_pkg for its depth.
module lr_cmd_fifo #(
  parameter int unsigned WIDTH = 61
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);
  import lr_pkg::*;

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(CmdDepth);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(CmdDepth - 1);

  logic [WIDTH-1:0] mem_q [CmdDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == Depth);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/lr_back.sv
// Back of the line rasterizer: runs the Bresenham stepper and holds the
// result register. Depends on lr_pkg.
module lr_back #(
  parameter int unsigned COORD_BITS = 8,
  parameter int unsigned CMD_W      = 7 * COORD_BITS + 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  logic [CMD_W-1:0]      cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_o
);
  import lr_pkg::*;

  localparam int unsigned EW = COORD_BITS + 2;
  localparam int unsigned DW = COORD_BITS + 3;

  // Unpacked command fields.
  logic                  c_kind;
  logic [COORD_BITS-1:0] c_sx, c_sy, c_ex, c_ey, c_spx, c_spy;
  logic                  c_dxn, c_dyn;
  logic [EW-1:0]         c_err;

  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [COORD_BITS-1:0] span_x_q, span_x_d, span_y_q, span_y_d;
  logic                  dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic [EW-1:0]         err_q, err_d;
  logic                  busy_q, busy_d;

  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] pixel_x_q, pixel_x_d, pixel_y_q, pixel_y_d;
  logic                  last_q, last_d;

  logic                  advance;
  logic                  is_tick;
  logic                  emit;
  logic                  at_end;
  logic signed [DW-1:0]  e2, sx_ext, sy_ext;
  logic                  step_x, step_y;
  logic [EW-1:0]         err_step;

  assign {c_kind, c_sx, c_sy, c_ex, c_ey, c_spx, c_spy, c_dxn, c_dyn, c_err} = cmd_i;

  assign is_tick   = (kind_e'(c_kind) == KIND_TICK);
  assign advance   = cmd_valid_i && (!out_valid_q || pop);
  assign cmd_pop_o = advance;

  // Doubled error against both spans, all in signed arithmetic.
  assign e2     = $signed({err_q, 1'b0});
  assign sx_ext = $signed({3'b000, span_x_q});
  assign sy_ext = $signed({3'b000, span_y_q});
  assign step_x = (e2 > -sy_ext);
  assign step_y = (e2 < sx_ext);
  assign err_step = err_q - (step_x ? {2'b00, span_y_q} : '0)
                          + (step_y ? {2'b00, span_x_q} : '0);

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    goal_x_d    = goal_x_q;
    goal_y_d    = goal_y_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    err_d       = err_q;
    emit        = 1'b0;
    if (advance) begin
      if (!is_tick) begin
        // Load: restart on the new endpoints.
        cur_x_d     = c_sx;
        cur_y_d     = c_sy;
        goal_x_d    = c_ex;
        goal_y_d    = c_ey;
        span_x_d    = c_spx;
        span_y_d    = c_spy;
        dir_x_neg_d = c_dxn;
        dir_y_neg_d = c_dyn;
        err_d       = c_err;
        emit        = 1'b1;
      end else if (busy_q) begin
        // Tick on a running line: take one step.
        err_d = err_step;
        if (step_x) begin
          cur_x_d = dir_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        end
        if (step_y) begin
          cur_y_d = dir_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
        end
        emit = 1'b1;
      end
      // A tick while idle is dropped without a result.
    end
  end

  assign at_end = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    pixel_x_d   = pixel_x_q;
    pixel_y_d   = pixel_y_q;
    last_d      = last_q;
    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      busy_d      = !at_end;
      out_valid_d = 1'b1;
      pixel_x_d   = cur_x_d;
      pixel_y_d   = cur_y_d;
      last_d      = at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      span_x_q    <= '0;
      span_y_q    <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
      err_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      span_x_q    <= span_x_d;
      span_y_q    <= span_y_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      err_q       <= err_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_x_q <= pixel_x_d;
    pixel_y_q <= pixel_y_d;
    last_q    <= last_d;
  end

  assign empty     = !out_valid_q;
  assign pixel_x_o = pixel_x_q;
  assign pixel_y_o = pixel_y_q;
  assign last_o    = last_q;

  // A running line never sits on its end point.
  a_busy_not_at_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !((cur_x_q == goal_x_q) && (cur_y_q == goal_y_q)))
    else $error("busy while at end point");

  // Going idle always coincides with a freshly stored last pixel.
  a_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> (out_valid_q && last_q))
    else $error("went idle without a last pixel");

  // A tick while idle leaves the position alone.
  a_idle_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && cmd_valid_i && is_tick) |=> ($stable(cur_x_q) && $stable(cur_y_q)))
    else $error("idle tick moved the position");

endmodule

>>> tb/sv/lr_pixel_check.sv
// Pixel scoreboard for the line rasterizer: traces each accepted beat through a
// Bresenham stepper of its own and compares every popped pixel field by field.
// Depends on lr_pkg for the beat kind.
module lr_pixel_check #(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  lr_pkg::kind_e         kind_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic                  last_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    pixels_checked_o
);
  import lr_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  pixel_t pending_pixels[$];
  pixel_t want;

  // Line state of the stepper.
  coord_t                  cur_x, cur_y, goal_x, goal_y, span_x, span_y;
  logic                    step_x_neg, step_y_neg, line_busy;
  logic signed [COORD_BITS+1:0] err_acc;

  task plot_pixel();
    pixel_t px;
    px.x = cur_x;
    px.y = cur_y;
    px.last = (cur_x == goal_x) && (cur_y == goal_y);
    line_busy = !px.last;
    pending_pixels.push_back(px);
  endtask

  task trace_beat(input kind_e kind, input coord_t sx, input coord_t sy,
                  input coord_t ex, input coord_t ey);
    int e2;
    if (kind == KIND_LOAD) begin
      cur_x = sx;
      cur_y = sy;
      goal_x = ex;
      goal_y = ey;
      span_x = (ex >= sx) ? coord_t'(ex - sx) : coord_t'(sx - ex);
      span_y = (ey >= sy) ? coord_t'(ey - sy) : coord_t'(sy - ey);
      step_x_neg = !(sx < ex);
      step_y_neg = !(sy < ey);
      err_acc = $signed({2'b00, span_x}) - $signed({2'b00, span_y});
      plot_pixel();
    end else if (line_busy) begin
      e2 = 2 * int'(err_acc);
      if (e2 > -int'(span_y)) begin
        err_acc = err_acc - $signed({2'b00, span_y});
        cur_x = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (e2 < int'(span_x)) begin
        err_acc = err_acc + $signed({2'b00, span_x});
        cur_y = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      plot_pixel();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x = '0;
      cur_y = '0;
      goal_x = '0;
      goal_y = '0;
      span_x = '0;
      span_y = '0;
      step_x_neg = 1'b0;
      step_y_neg = 1'b0;
      line_busy = 1'b0;
      err_acc = '0;
      pending_pixels.delete();
      fail_count_o = 0;
      pending_o = 0;
      pixels_checked_o = 0;
    end else begin
      // Check the popped pixel before tracing the new beat.
      if (pop_i && !empty_i) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel (%0d,%0d) last=%0b", pixel_x_i, pixel_y_i, last_i);
          fail_count_o++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked_o++;
          if (pixel_x_i !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, pixel_x_i);
            fail_count_o++;
          end
          if (pixel_y_i !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, pixel_y_i);
            fail_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            fail_count_o++;
          end
        end
      end
      if (push_i && !full_i) begin
        trace_beat(kind_i, start_x_i, start_y_i, end_x_i, end_y_i);
      end
      pending_o = pending_pixels.size();
    end
  end

endmodule

>>> tb/sv/line_rasterizer_tb.sv
// Top of the line rasterizer testbench: clock, reset, beat stimulus and pop
// stall, with lr_pixel_check predicting and comparing. Depends on lr_pkg,
// lr_pixel_check and line_rasterizer.
module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int unsigned CoordBits = 8;
  localparam int unsigned ItemTarget = 1200;
  localparam int unsigned CoordMax = (1 << CoordBits) - 1;

  typedef logic [CoordBits-1:0] coord_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   push = 1'b0;
  logic   full;
  kind_e  kind = KIND_TICK;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic   empty;
  logic   pop = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last;

  int fail_count;
  int pending;
  int pixels_checked;

  // Burst flags: while set, the side takes no gaps at all.
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;

  int beats_sent = 0;
  int produced = 0;
  int lines_drawn = 0;
  int lines_cut = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  line_rasterizer #(
    .COORD_BITS(CoordBits)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .kind_i    (kind),
    .start_x_i (start_x),
    .start_y_i (start_y),
    .end_x_i   (end_x),
    .end_y_i   (end_y),
    .empty     (empty),
    .pop       (pop),
    .pixel_x_o (pixel_x),
    .pixel_y_o (pixel_y),
    .last_o    (last)
  );

  lr_pixel_check #(
    .COORD_BITS(CoordBits)
  ) pixel_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .kind_i           (kind),
    .start_x_i        (start_x),
    .start_y_i        (start_y),
    .end_x_i          (end_x),
    .end_y_i          (end_y),
    .empty_i          (empty),
    .pop_i            (pop),
    .pixel_x_i        (pixel_x),
    .pixel_y_i        (pixel_y),
    .last_i           (last),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .pixels_checked_o (pixels_checked)
  );

  // Push one beat. Entered and left at a falling edge; an optional gap of
  // idle cycles comes first, then hold push until the beat is taken.
  task send_beat(input kind_e k, input coord_t sx, input coord_t sy,
                 input coord_t ex, input coord_t ey);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind <= k;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Load a line, then send the given number of ticks. Ticks carry random
  // coordinates, which the block must ignore. Ticks past the end point are
  // idle ticks and yield no pixel.
  task draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
                 input coord_t ey, input int ticks);
    int steps;
    int dx;
    int dy;
    dx = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
    dy = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
    steps = (dx > dy) ? dx : dy;
    send_beat(KIND_LOAD, sx, sy, ex, ey);
    for (int i = 0; i < ticks; i++) begin
      send_beat(KIND_TICK, $urandom, $urandom, $urandom, $urandom);
    end
    produced += 1 + ((ticks < steps) ? ticks : steps);
    lines_drawn++;
    if (ticks < steps) lines_cut++;
  endtask

  // Hold off the sender until every predicted pixel has been popped.
  task drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Pick an endpoint within reach of c, clamped to the coordinate range.
  function automatic coord_t near(input coord_t c, input int reach);
    int lo;
    int hi;
    lo = int'(c) - reach;
    hi = int'(c) + reach;
    if (lo < 0) lo = 0;
    if (hi > int'(CoordMax)) hi = int'(CoordMax);
    return coord_t'($urandom_range(lo, hi));
  endfunction

  // Result side: draw a stall per pixel, with bursts of back-to-back pops.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Stimulus and verdict.
  initial begin
    int pick;
    int reach;
    int shape;
    int steps;
    int ticks;
    int waited;
    int failures;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed lines. Tick while idle first: it must yield nothing.
    send_beat(KIND_TICK, '1, '1, '1, '1);
    // Single-pixel lines at both corners; the tick after one is idle.
    draw_line(8'd0, 8'd0, 8'd0, 8'd0, 1);
    draw_line(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    // Full-range diagonals, dropped by the next load while still running.
    draw_line(8'd0, 8'd0, 8'hFF, 8'hFF, 2);
    draw_line(8'hFF, 8'd0, 8'd0, 8'hFF, 1);
    // Vertical line (x equal), plus one idle tick past its end.
    draw_line(8'd5, 8'd5, 8'd5, 8'd7, 3);
    // Horizontal line toward smaller x (y equal).
    draw_line(8'd9, 8'd4, 8'd6, 8'd4, 3);
    // Steep line toward smaller y, then a shallow one in another octant.
    draw_line(8'd20, 8'd20, 8'd22, 8'd15, 5);
    draw_line(8'd12, 8'd30, 8'd16, 8'd28, 4);
    drain();

    // Random lines: mostly short ones run to the end, some dropped early,
    // some with stray ticks, and a few spanning the whole range.
    while (beats_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      reach = (pick < 80) ? 15 : (pick < 97) ? 60 : CoordMax;
      sx = $urandom;
      sy = $urandom;
      ex = near(sx, reach);
      ey = near(sy, reach);
      steps = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
      steps = (ey >= sy) ? ((int'(ey) - int'(sy) > steps) ? int'(ey) - int'(sy) : steps)
                         : ((int'(sy) - int'(ey) > steps) ? int'(sy) - int'(ey) : steps);
      shape = $urandom_range(0, 99);
      if (shape < 70) begin
        ticks = steps + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
      end else if (shape < 85) begin
        ticks = (steps == 0) ? 0 : $urandom_range(0, steps - 1);
      end else begin
        ticks = $urandom_range(0, 2 * steps + 2);
      end
      tx_burst = ($urandom_range(0, 5) == 0);
      draw_line(sx, sy, ex, ey, ticks);
      if (lines_drawn % 97 == 0) drain();
    end

    // Let the last pixels come out, then watch a few more cycles for strays.
    push <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);

    failures = fail_count + pending;
    if (pending != 0) $error("%0d predicted pixels never came out", pending);
    $display("Sent %0d beats over %0d lines (%0d dropped early by a new load);",
             beats_sent, lines_drawn, lines_cut);
    $display("compared %0d of %0d expected pixels against the predicted Bresenham path.",
             pixels_checked, produced);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> line_rasterizer.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_cmd_fifo.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer.sv
tb/sv/lr_pixel_check.sv
tb/sv/line_rasterizer_tb.sv
